// ----- rtl/traffic_lane_ca_step_macros.svh -----
// assertion macros shared by the checker files
`ifndef TRAFFIC_LANE_CA_STEP_MACROS_SVH
`define TRAFFIC_LANE_CA_STEP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TLCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TLCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tlca_pkg.sv -----
package tlca_pkg;

  // default number of stored road cells
  localparam int LANE_CELLS_DEF = 64;

  // field widths
  localparam int VEL_W      = 4;
  localparam int IDX_W      = 6;
  localparam int LANE_W     = 7;
  localparam int BITS_W     = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_LENGTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_BOUNDARY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SPEED   = CFG_IDX_W'(3);

  // configuration reset values
  localparam logic [VEL_W-1:0]  MAX_SPEED_RST   = VEL_W'(5);
  localparam logic [LANE_W-1:0] LANE_LENGTH_RST = LANE_W'(64);
  localparam logic              OPEN_RST        = 1'b0;
  localparam logic [VEL_W-1:0]  ENTRY_SPEED_RST = VEL_W'(1);

endpackage

// ----- rtl/tlca_in_if.sv -----
interface tlca_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [tlca_pkg::IDX_W-1:0]    cell_index;
  logic                          cell_full;
  logic [tlca_pkg::VEL_W-1:0]    cell_speed;
  logic [tlca_pkg::BITS_W-1:0]   random_bits;

  modport source (output valid, op, cell_index, cell_full, cell_speed, random_bits,
                  input ready);
  modport sink   (input valid, op, cell_index, cell_full, cell_speed, random_bits,
                  output ready);
endinterface

// ----- rtl/tlca_out_if.sv -----
interface tlca_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlca_pkg::IDX_W-1:0] out_index;
  logic                       out_full;
  logic [tlca_pkg::VEL_W-1:0] out_speed;
  logic                       out_last;

  modport source (output valid, out_index, out_full, out_speed, out_last, input ready);
  modport sink   (input valid, out_index, out_full, out_speed, out_last, output ready);
endinterface

// ----- rtl/tlca_cfg_if.sv -----
interface tlca_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tlca_pkg::CFG_IDX_W-1:0]  index;
  logic [tlca_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tlca_ram.sv -----
module tlca_ram #(
  parameter int WIDTH = tlca_pkg::VEL_W,
  parameter int DEPTH = tlca_pkg::LANE_CELLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/traffic_lane_ca_step.sv -----
// Single-lane traffic cellular automaton. A load beat (op 0) writes one cell. A step beat
// (op 1) on a road of n cells runs from its accept through a sweep that reads each cell once
// through the speed memory's single read port and updates each car as the next car ahead is
// found, a state that settles the last car, one that handles injection, then n output beats,
// one per cell, read again through the same port into the read and output registers, and
// held while the output side stalls. The input is not ready during a step. Occupancy lives
// in flip-flops cleared by reset; speeds live in a RAM and are read for every cell.
module traffic_lane_ca_step #(
  parameter int LANE_CELLS = tlca_pkg::LANE_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlca_in_if.sink    in_ch,
  tlca_out_if.source out_ch,
  tlca_cfg_if.sink   cfg_ch
);

  localparam int IW = $clog2(LANE_CELLS);
  localparam int NW = $clog2(LANE_CELLS + 1);
  localparam int GW = (NW + 1 > 5) ? NW + 1 : 5;
  localparam int CW = (NW > tlca_pkg::LANE_W) ? NW : tlca_pkg::LANE_W;
  localparam int VW = tlca_pkg::VEL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_LAST,
    S_INJECT,
    S_OUT
  } state_t;

  // speed update for one car given its gap to the car ahead
  function automatic logic [VW-1:0] new_speed(input logic [VW-1:0] v,
                                              input logic [GW-1:0] d,
                                              input logic [VW-1:0] vmax,
                                              input logic          slow);
    logic [VW-1:0] s;
    logic [GW-1:0] v_ext;
    v_ext = GW'(v);
    s     = v;
    if ((v < vmax) && (d > v_ext + GW'(1))) begin
      s = v + VW'(1);
    end else if ((v != '0) && (d <= v_ext)) begin
      s = d[VW-1:0] - VW'(1);
    end
    if (slow && (s != '0)) begin
      s = s - VW'(1);
    end
    return s;
  endfunction

  state_t                     state_r, state_nxt;
  logic [LANE_CELLS-1:0]      occ_r, occ_nxt;
  logic [NW-1:0]              n_r, n_nxt;
  logic [IW-1:0]              scan_idx_r, scan_idx_nxt;
  logic                       hit_r, hit_nxt;
  logic [IW-1:0]              hit_idx_r, hit_idx_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic [IW-1:0]              prev_pos_r, prev_pos_nxt;
  logic [VW-1:0]              prev_vel_r, prev_vel_nxt;
  logic [IW-1:0]              first_pos_r, first_pos_nxt;
  logic [tlca_pkg::BITS_W-1:0] bits_r, bits_nxt;
  logic                       rd_done_r, rd_done_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_full_r, pend_full_nxt;
  logic [IW-1:0]              pend_idx_r, pend_idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [tlca_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic                       out_full_r, out_full_nxt;
  logic [VW-1:0]              out_speed_r, out_speed_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [VW-1:0]              cfg_max_r, cfg_max_nxt;
  logic [tlca_pkg::LANE_W-1:0] cfg_lane_r, cfg_lane_nxt;
  logic                       cfg_open_r, cfg_open_nxt;
  logic [VW-1:0]              cfg_entry_r, cfg_entry_nxt;

  // speed memory ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  // shared car update unit
  logic          fin_go;
  logic [GW-1:0] fin_gap;
  logic [GW-1:0] gap_scan;
  logic [GW-1:0] gap_last;
  logic [VW-1:0] fin_speed;
  logic [GW-1:0] fin_sum;
  logic [GW-1:0] fin_dest;
  logic          fin_keep;
  logic [GW-1:0] n_ext;

  // sweep helpers
  logic [IW-1:0] last_idx;
  logic [CW-1:0] ln_ext;
  logic [CW-1:0] ln_sat;
  logic          slot_free;
  logic          load_out;
  logic          issue;

  tlca_ram #(
    .WIDTH (VW),
    .DEPTH (LANE_CELLS)
  ) u_tlca_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_index_r;
  assign out_ch.out_full  = out_full_r;
  assign out_ch.out_speed = out_speed_r;
  assign out_ch.out_last  = out_last_r;

  // road length clamped to the stored cells
  always_comb begin
    ln_ext = CW'(cfg_lane_r);
    if (ln_ext < CW'(2)) begin
      ln_sat = CW'(2);
    end else if (ln_ext > CW'(LANE_CELLS)) begin
      ln_sat = CW'(LANE_CELLS);
    end else begin
      ln_sat = ln_ext;
    end
  end

  assign last_idx = IW'(n_r - NW'(1));
  assign n_ext    = GW'(n_r);

  // gaps: to the car just found, or past the last car
  assign gap_scan = GW'(hit_idx_r) - GW'(prev_pos_r);
  assign gap_last = cfg_open_r ? (n_ext << 1)
                               : GW'(first_pos_r) + n_ext - GW'(prev_pos_r);
  assign fin_gap  = (state_r == S_LAST) ? gap_last : gap_scan;

  // new speed and landing cell of the pending car
  always_comb begin
    fin_speed = new_speed(prev_vel_r, fin_gap, cfg_max_r, bits_r[0]);
    fin_sum   = GW'(prev_pos_r) + GW'(fin_speed);
    fin_keep  = 1'b1;
    fin_dest  = fin_sum;
    if (fin_sum >= n_ext) begin
      if (cfg_open_r) begin
        fin_keep = 1'b0;
      end else begin
        fin_dest = fin_sum - n_ext;
      end
    end
  end

  // output slot handshake
  assign slot_free = !out_valid_r || out_ch.ready;
  assign load_out  = (state_r == S_OUT) && pend_r && slot_free;
  assign issue     = (state_r == S_OUT) && !rd_done_r && (!pend_r || slot_free);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    n_nxt         = n_r;
    scan_idx_nxt  = scan_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    have_prev_nxt = have_prev_r;
    prev_pos_nxt  = prev_pos_r;
    prev_vel_nxt  = prev_vel_r;
    first_pos_nxt = first_pos_r;
    bits_nxt      = bits_r;
    rd_done_nxt   = rd_done_r;
    pend_nxt      = pend_r;
    pend_full_nxt = pend_full_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_full_nxt  = out_full_r;
    out_speed_nxt = out_speed_r;
    out_last_nxt  = out_last_r;
    cfg_max_nxt   = cfg_max_r;
    cfg_lane_nxt  = cfg_lane_r;
    cfg_open_nxt  = cfg_open_r;
    cfg_entry_nxt = cfg_entry_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = scan_idx_r;
    fin_go        = 1'b0;

    // register writes
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tlca_pkg::CFG_MAX_SPEED:     cfg_max_nxt   = cfg_ch.data[VW-1:0];
        tlca_pkg::CFG_LANE_LENGTH:   cfg_lane_nxt  = cfg_ch.data[tlca_pkg::LANE_W-1:0];
        tlca_pkg::CFG_OPEN_BOUNDARY: cfg_open_nxt  = cfg_ch.data[0];
        tlca_pkg::CFG_ENTRY_SPEED:   cfg_entry_nxt = cfg_ch.data[VW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.op)
            tlca_pkg::OP_LOAD: begin
              if (32'(in_ch.cell_index) < 32'(LANE_CELLS)) begin
                occ_nxt[IW'(in_ch.cell_index)] = in_ch.cell_full;
                ram_we    = 1'b1;
                ram_waddr = IW'(in_ch.cell_index);
                ram_wdata = in_ch.cell_full ? in_ch.cell_speed : '0;
              end
            end
            tlca_pkg::OP_STEP: begin
              n_nxt         = NW'(ln_sat);
              bits_nxt      = in_ch.random_bits;
              scan_idx_nxt  = '0;
              hit_nxt       = 1'b0;
              have_prev_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN, S_DRAIN: begin
        // the car found last cycle closes the gap of the one before it
        if (hit_r) begin
          fin_go        = have_prev_r;
          prev_pos_nxt  = hit_idx_r;
          prev_vel_nxt  = ram_rdata;
          have_prev_nxt = 1'b1;
          if (!have_prev_r) begin
            first_pos_nxt = hit_idx_r;
          end
        end
        if (state_r == S_SCAN) begin
          ram_re      = 1'b1;
          hit_nxt     = occ_r[scan_idx_r];
          hit_idx_nxt = scan_idx_r;
          if (scan_idx_r == last_idx) begin
            state_nxt = S_DRAIN;
          end else begin
            scan_idx_nxt = scan_idx_r + IW'(1);
          end
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_LAST;
        end
      end

      S_LAST: begin
        fin_go    = have_prev_r;
        state_nxt = S_INJECT;
      end

      S_INJECT: begin
        if (cfg_open_r && !occ_r[0] && bits_r[0]) begin
          occ_nxt[0] = 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = cfg_entry_r;
        end
        scan_idx_nxt = '0;
        rd_done_nxt  = 1'b0;
        pend_nxt     = 1'b0;
        state_nxt    = S_OUT;
      end

      S_OUT: begin
        if (out_valid_r && out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = tlca_pkg::IDX_W'(pend_idx_r);
          out_full_nxt  = pend_full_r;
          out_speed_nxt = pend_full_r ? ram_rdata : '0;
          out_last_nxt  = (pend_idx_r == last_idx);
          pend_nxt      = 1'b0;
        end
        if (issue) begin
          ram_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_full_nxt = occ_r[scan_idx_r];
          pend_idx_nxt  = scan_idx_r;
          if (scan_idx_r == last_idx) begin
            rd_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + IW'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // apply the pending car's update: vacate, then land
    if (fin_go) begin
      occ_nxt[prev_pos_r] = 1'b0;
      if (fin_keep) begin
        occ_nxt[IW'(fin_dest)] = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = IW'(fin_dest);
        ram_wdata = fin_speed;
      end
      bits_nxt = bits_r >> 1;
    end
  end

  // state, control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      hit_r       <= 1'b0;
      have_prev_r <= 1'b0;
      rd_done_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_max_r   <= tlca_pkg::MAX_SPEED_RST;
      cfg_lane_r  <= tlca_pkg::LANE_LENGTH_RST;
      cfg_open_r  <= tlca_pkg::OPEN_RST;
      cfg_entry_r <= tlca_pkg::ENTRY_SPEED_RST;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      hit_r       <= hit_nxt;
      have_prev_r <= have_prev_nxt;
      rd_done_r   <= rd_done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_max_r   <= cfg_max_nxt;
      cfg_lane_r  <= cfg_lane_nxt;
      cfg_open_r  <= cfg_open_nxt;
      cfg_entry_r <= cfg_entry_nxt;
      n_r         <= n_nxt;
      scan_idx_r  <= scan_idx_nxt;
      hit_idx_r   <= hit_idx_nxt;
      prev_pos_r  <= prev_pos_nxt;
      prev_vel_r  <= prev_vel_nxt;
      first_pos_r <= first_pos_nxt;
      bits_r      <= bits_nxt;
      pend_full_r <= pend_full_nxt;
      pend_idx_r  <= pend_idx_nxt;
      out_index_r <= out_index_nxt;
      out_full_r  <= out_full_nxt;
      out_speed_r <= out_speed_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

endmodule

// ----- rtl/tlca_checker.sv -----
`include "traffic_lane_ca_step_macros.svh"

module tlca_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tlca_pkg::IDX_W-1:0] out_index,
  input logic                       out_full,
  input logic [tlca_pkg::VEL_W-1:0] out_speed,
  input logic                       out_last
);

  // no new item is taken while road beats are still on offer
  `TLCA_ASSERT_IMP(a_in_out_excl, clk, rst_n, in_ready, !out_valid, "input ready during output")

  // a step keeps the input closed on the following cycle
  `TLCA_ASSERT_NXT(a_step_busy, clk, rst_n, in_valid && in_ready && in_op == tlca_pkg::OP_STEP, !in_ready, "input ready right after step")

  // an empty cell reports zero speed
  `TLCA_ASSERT_IMP(a_empty_speed, clk, rst_n, out_valid && !out_full, out_speed == '0, "empty cell with speed")

  // the final beat of a road ends the output burst
  `TLCA_ASSERT_NXT(a_last_done, clk, rst_n, out_valid && out_ready && out_last, !out_valid, "beat after last cell")

  // a stalled beat holds its cell number
  `TLCA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_index), "stalled beat changed")

endmodule

bind traffic_lane_ca_step tlca_checker u_tlca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_index),
  .out_full  (out_ch.out_full),
  .out_speed (out_ch.out_speed),
  .out_last  (out_ch.out_last)
);

// ----- dv/tb_traffic_lane_ca_step.sv -----
`timescale 1ns / 100ps

module tb_traffic_lane_ca_step;
  import tlca_pkg::*;

  localparam int LANE_CELLS    = LANE_CELLS_DEF;
  localparam int ITEM_TARGET   = 380;
  localparam int TAIL_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 2 * LANE_CELLS + 8;
  localparam int CYCLE_LIMIT   = 3_000_000;

  // an index that names no register
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_IDX_W'(15);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             full;
    logic [VEL_W-1:0] speed;
    logic             last;
  } cell_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  tlca_in_if  in_ch ();
  tlca_out_if out_ch ();
  tlca_cfg_if cfg_ch ();

  traffic_lane_ca_step #(.LANE_CELLS(LANE_CELLS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted road and register copies
  bit               road_occ [LANE_CELLS];
  logic [VEL_W-1:0] road_vel [LANE_CELLS];
  logic [VEL_W-1:0] set_max_speed   = MAX_SPEED_RST;
  logic [LANE_W-1:0] set_lane_length = LANE_LENGTH_RST;
  logic             set_open        = OPEN_RST;
  logic [VEL_W-1:0] set_entry_speed = ENTRY_SPEED_RST;

  cell_beat_t expected_cells [$];
  cell_beat_t want_cell;
  cell_beat_t got_cell;

  int  mismatch_count = 0;
  int  cells_checked  = 0;
  int  items_sent     = 0;
  int  steps_sent     = 0;
  int  reg_writes     = 0;
  int  cycles         = 0;
  int  sink_hold      = 0;
  bit  src_idle_on    = 1'b1;
  bit  sink_idle_on   = 1'b1;
  bit  quiet_tail     = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_on && !quiet_tail && $urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest predicted cell
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_cell = '{out_ch.out_index, out_ch.out_full, out_ch.out_speed, out_ch.out_last};
      if (expected_cells.size() == 0) begin
        $display("%0t: result beat with nothing expected: index %0d full %0b speed %0d last %0b",
                 $time, got_cell.idx, got_cell.full, got_cell.speed, got_cell.last);
        mismatch_count++;
      end else begin
        want_cell = expected_cells.pop_front();
        cells_checked++;
        if (got_cell.idx !== want_cell.idx || got_cell.full !== want_cell.full ||
            got_cell.speed !== want_cell.speed || got_cell.last !== want_cell.last) begin
          $display("%0t: cell mismatch, expected index %0d full %0b speed %0d last %0b",
                   $time, want_cell.idx, want_cell.full, want_cell.speed, want_cell.last);
          $display("%0t:                  actual index %0d full %0b speed %0d last %0b",
                   $time, got_cell.idx, got_cell.full, got_cell.speed, got_cell.last);
          mismatch_count++;
        end
      end
    end
  end

  // lane length as the block uses it
  function automatic int road_cells(input logic [LANE_W-1:0] lane);
    int n;
    n = lane;
    if (n < 2) n = 2;
    if (n > LANE_CELLS) n = LANE_CELLS;
    return n;
  endfunction

  // append one predicted cell to the tail of the queue
  function automatic void queue_cell(input cell_beat_t beat);
    expected_cells = {expected_cells, beat};
  endfunction

  // one time step of the road, queueing the whole new road
  function automatic void advance_road(input logic [BITS_W-1:0] slow_bits);
    int n, i, d, p, tap, vel;
    bit ahead;
    bit nocc [LANE_CELLS];
    logic [VEL_W-1:0] nvel [LANE_CELLS];
    cell_beat_t beat;
    n = road_cells(set_lane_length);
    tap = 0;
    // speed update in cell order against the old occupancy
    for (i = 0; i < n; i++) begin
      if (!road_occ[i]) continue;
      vel = road_vel[i];
      d = 1;
      while (d < 2 * n) begin
        p = i + d;
        if (set_open) ahead = (p < n) ? road_occ[p] : 1'b0;
        else ahead = road_occ[p % n];
        if (ahead) break;
        d++;
      end
      if (vel < int'(set_max_speed) && d > vel + 1) vel++;
      else if (vel > 0 && d <= vel) vel = d - 1;
      if (tap < BITS_W && slow_bits[tap] && vel > 0) vel--;
      tap++;
      road_vel[i] = vel[VEL_W-1:0];
    end
    // movement, the later cell wins a shared landing spot
    for (i = 0; i < LANE_CELLS; i++) begin
      nocc[i] = 1'b0;
      nvel[i] = '0;
    end
    for (i = 0; i < n; i++) begin
      if (!road_occ[i]) continue;
      p = i + road_vel[i];
      if (set_open) begin
        if (p >= n) continue;
      end else begin
        p = p % n;
      end
      nocc[p] = 1'b1;
      nvel[p] = road_vel[i];
    end
    for (i = 0; i < n; i++) begin
      road_occ[i] = nocc[i];
      road_vel[i] = nvel[i];
    end
    // injection at an empty entry cell
    if (set_open && !road_occ[0] && tap < BITS_W && slow_bits[tap]) begin
      road_occ[0] = 1'b1;
      road_vel[0] = set_entry_speed;
    end
    for (i = 0; i < n; i++) begin
      beat.idx   = i[IDX_W-1:0];
      beat.full  = road_occ[i];
      beat.speed = road_occ[i] ? road_vel[i] : '0;
      beat.last  = (i == n - 1);
      queue_cell(beat);
    end
  endfunction

  function automatic logic [BITS_W-1:0] draw_slow_bits();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // send one item and predict once its beat is taken
  task automatic issue_item(input logic op, input logic [IDX_W-1:0] idx, input logic full,
                            input logic [VEL_W-1:0] spd, input logic [BITS_W-1:0] bits);
    if (src_idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.cell_index  <= idx;
    in_ch.cell_full   <= full;
    in_ch.cell_speed  <= spd;
    in_ch.random_bits <= bits;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op == OP_STEP) begin
      steps_sent++;
      advance_road(bits);
    end else begin
      road_occ[idx] = full;
      road_vel[idx] = full ? spd : '0;
    end
  endtask

  task automatic load_cell(input int idx, input logic full, input int spd);
    issue_item(OP_LOAD, IDX_W'(idx), full, VEL_W'(spd), {$urandom, $urandom});
  endtask

  task automatic run_step(input logic [BITS_W-1:0] bits);
    issue_item(OP_STEP, IDX_W'($urandom), 1'($urandom), VEL_W'($urandom), bits);
  endtask

  // wait until every cell has come back and a trailing load has settled
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    quiesce();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_MAX_SPEED:     set_max_speed   = data[VEL_W-1:0];
      CFG_LANE_LENGTH:   set_lane_length = data[LANE_W-1:0];
      CFG_OPEN_BOUNDARY: set_open        = data[0];
      CFG_ENTRY_SPEED:   set_entry_speed = data[VEL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // reset defaults: empty 64-cell ring, then a lone car faster than the limit
  task automatic test_empty_after_reset();
    run_step('0);
    load_cell(63, 1'b1, 15);
    run_step('0);
  endtask

  // short ring with a stopped car, a car at the speed limit and an empty load carrying a speed
  task automatic test_short_circular();
    write_reg(CFG_MAX_SPEED, 8'hAF);
    write_reg(CFG_LANE_LENGTH, 8'h88);
    write_reg(CFG_OPEN_BOUNDARY, 8'hFE);
    load_cell(0, 1'b1, 0);
    load_cell(1, 1'b1, 15);
    load_cell(3, 1'b0, 9);
    load_cell(5, 1'b1, 0);
    load_cell(7, 1'b1, 3);
    run_step('1);
    run_step('0);
    run_step({$urandom, $urandom});
  endtask

  // open road: a car leaves the end, entry cars at both entry speed extremes
  task automatic test_open_road();
    write_reg(CFG_OPEN_BOUNDARY, 8'h01);
    write_reg(CFG_ENTRY_SPEED, 8'h0F);
    write_reg(CFG_LANE_LENGTH, 8'h04);
    write_reg(CFG_MAX_SPEED, 8'h01);
    load_cell(3, 1'b1, 2);
    run_step('1);
    run_step('0);
    run_step(64'h2);
    write_reg(CFG_ENTRY_SPEED, 8'hF0);
    load_cell(0, 1'b0, 0);
    run_step('1);
  endtask

  // cells past the lane survive short lanes; lane length saturates at both ends
  task automatic test_hidden_cells();
    write_reg(CFG_OPEN_BOUNDARY, 8'h00);
    write_reg(CFG_MAX_SPEED, 8'h00);
    load_cell(40, 1'b1, 2);
    write_reg(CFG_LANE_LENGTH, 8'h00);
    write_reg(CFG_NO_REG, 8'hFF);
    run_step({$urandom, $urandom});
    write_reg(CFG_LANE_LENGTH, 8'h7F);
    write_reg(CFG_MAX_SPEED, 8'h05);
    run_step('0);
  endtask

  // every cell full: the slow-down bits run out
  task automatic test_full_road();
    int k;
    write_reg(CFG_LANE_LENGTH, 8'h40);
    write_reg(CFG_MAX_SPEED, 8'h0F);
    write_reg(CFG_OPEN_BOUNDARY, 8'h01);
    for (k = 0; k < LANE_CELLS; k++) load_cell(k, 1'b1, $urandom_range(0, 15));
    run_step('1);
    write_reg(CFG_OPEN_BOUNDARY, 8'h00);
    for (k = 0; k < LANE_CELLS; k++) load_cell(k, 1'b1, $urandom_range(0, 15));
    run_step({$urandom, $urandom});
  endtask

  // phases of random settings, a few loads and a run of steps on the evolving road
  task automatic test_random_traffic();
    int n_eff, loads, steps, density, k;
    logic [LANE_W-1:0] lane_pick;
    logic [VEL_W-1:0] top_speed;
    while (items_sent < ITEM_TARGET) begin
      quiet_tail = (items_sent >= ITEM_TARGET - TAIL_ITEMS);
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 5))
            0: lane_pick = 7'd0;
            1: lane_pick = 7'd1;
            2: lane_pick = 7'd2;
            3: lane_pick = 7'd64;
            4: lane_pick = 7'd65;
            default: lane_pick = 7'd127;
          endcase
        end
        1: lane_pick = LANE_W'($urandom_range(17, 64));
        default: lane_pick = LANE_W'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 4))
        0: top_speed = 4'd0;
        1: top_speed = 4'd1;
        2: top_speed = 4'd15;
        default: top_speed = VEL_W'($urandom_range(1, 15));
      endcase
      write_reg(CFG_MAX_SPEED, {4'($urandom), top_speed});
      write_reg(CFG_LANE_LENGTH, {1'($urandom), lane_pick});
      write_reg(CFG_OPEN_BOUNDARY, {7'($urandom), 1'($urandom)});
      write_reg(CFG_ENTRY_SPEED, {4'($urandom), 4'($urandom)});
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      n_eff   = road_cells(lane_pick);
      density = $urandom_range(0, 100);
      loads   = $urandom_range(1, (n_eff < 20) ? n_eff : 20);
      for (k = 0; k < loads; k++) begin
        load_cell(($urandom_range(0, 7) == 0) ? $urandom_range(0, LANE_CELLS - 1)
                                              : $urandom_range(0, n_eff - 1),
                  ($urandom_range(0, 99) < density),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(0, top_speed));
      end
      steps = $urandom_range(3, 8);
      for (k = 0; k < steps; k++) run_step(draw_slow_bits());
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_LOAD;
    in_ch.cell_index   <= '0;
    in_ch.cell_full    <= 1'b0;
    in_ch.cell_speed   <= '0;
    in_ch.random_bits  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_MAX_SPEED;
    cfg_ch.data        <= '0;
    for (int i = 0; i < LANE_CELLS; i++) begin
      road_occ[i] = 1'b0;
      road_vel[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_after_reset();
    test_short_circular();
    test_open_road();
    test_hidden_cells();
    test_full_road();
    test_random_traffic();

    // drain with no idling
    quiet_tail = 1'b1;
    quiesce();
    $display("covered %0d items (%0d road steps) over %0d register writes",
             items_sent, steps_sent, reg_writes);
    $display("checked %0d cell beats, %0d mismatches", cells_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
